[rtl/core/chord_voice_leader_core_assert.svh]
// Assertion macros for the chord voice leader core.
// Used by the top level; expects clk and rst in scope.
`ifndef CHORD_VOICE_LEADER_CORE_ASSERT_SVH
`define CHORD_VOICE_LEADER_CORE_ASSERT_SVH

// checked outside reset
`define CVL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CVL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/cvl_pkg.sv]
// Shared types, constants and pitch-class helpers for the chord voice leader.
// No dependencies.
package cvl_pkg;

  localparam int NUM_VOICES = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 4;

  typedef logic [6:0] note_t;
  typedef logic [3:0] pc_t;
  typedef logic signed [3:0] offset_t;
  typedef note_t [NUM_VOICES-1:0] voicing_t;
  typedef pc_t [NUM_VOICES-1:0] tone_pcs_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY  = 1'd0,
    REG_MODE = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    QUAL_MAJ7    = 3'd0,
    QUAL_DOM7    = 3'd1,
    QUAL_M7B5    = 3'd2,
    QUAL_MINMAJ7 = 3'd3,
    QUAL_MIN7    = 3'd4
  } quality_t;

  // scale steps per mode: lydian, dorian, mixolydian, aeolian
  localparam logic [3:0] MODE_STEPS [4][7] = '{
    '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10},
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10}
  };

  // home notes 45+5k and their pitch classes
  localparam note_t HOME_NOTE [NUM_VOICES] = '{7'd45, 7'd50, 7'd55, 7'd60};
  localparam pc_t   HOME_PC   [NUM_VOICES] = '{4'd9, 4'd2, 4'd7, 4'd0};

  localparam note_t NOTE_LOW  = 7'd40;
  localparam note_t NOTE_HIGH = 7'd67;
  localparam note_t OCTAVE    = 7'd12;
  // any note in 40..67 minus this lands in 4..31
  localparam note_t PC_BIAS   = 7'd36;

  // reduce a value below 32 to a pitch class
  function automatic pc_t pc_wrap(logic [4:0] v);
    logic [4:0] r;
    if (v >= 5'd24) r = v - 5'd24;
    else if (v >= 5'd12) r = v - 5'd12;
    else r = v;
    return r[3:0];
  endfunction

  // pitch class of a folded note (40..67)
  function automatic pc_t note_pc(note_t n);
    logic [6:0] t;
    t = n - PC_BIAS;
    return pc_wrap(t[4:0]);
  endfunction

  // signed distance -6..5 from ref_pc up or down to pc
  function automatic offset_t near_offset(pc_t pc, pc_t ref_pc);
    logic [3:0] m;
    m = pc - ref_pc;
    if (pc < ref_pc) m = m + 4'd12;
    if (m >= 4'd6) m = m - 4'd12;
    return $signed(m);
  endfunction

  function automatic logic [2:0] offset_mag(offset_t off);
    offset_t a;
    a = (off < 0) ? -off : off;
    return a[2:0];
  endfunction

  function automatic note_t apply_offset(note_t n, offset_t off);
    return n + {{3{off[3]}}, off};
  endfunction

  // one octave step covers every note the leader can produce (34..72)
  function automatic note_t fold(note_t n);
    if (n < NOTE_LOW) return n + OCTAVE;
    else if (n > NOTE_HIGH) return n - OCTAVE;
    else return n;
  endfunction

endpackage

[rtl/core/chord_voice_leader_core.sv]
// Top level of the chord voice leader: input register, chord builder,
// voice leader and result register. Depends on cvl_pkg and cvl_voice_lead.
//
//   port group   direction  handshake            payload
//   in           in         in_valid/in_ready    degree, fresh_start
//   out          out        out_valid/out_ready  voice_zero..voice_three, root_pc, quality
//   cfg          in         cfg_write            cfg_index, cfg_data
//
// Throughput is one item per cycle while no result is stalled; an accepted item
// passes through the input register, then the chord/voicing logic into the result
// register. The stored voicing doubles as the voice fields of the result.
// A stalled result holds both registers; the next item then waits in the
// input register. Synchronous reset clears handshake state, the stored voicing
// flag and the configuration registers; no clearing pass is needed.
module chord_voice_leader_core
  import cvl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             degree,
  input  logic                   fresh_start,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [6:0]             voice_zero,
  output logic [6:0]             voice_one,
  output logic [6:0]             voice_two,
  output logic [6:0]             voice_three,
  output logic [3:0]             root_pc,
  output logic [2:0]             quality,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "chord_voice_leader_core_assert.svh"

  logic [3:0] key_pitch_class;
  logic [1:0] mode_select;

  logic       s1_valid;
  logic [2:0] s1_degree;
  logic       s1_fresh;
  logic       s1_advance;
  logic       in_fire;

  logic       voices_valid;
  voicing_t   voice_notes;
  voicing_t   voice_notes_next;
  tone_pcs_t  tone_pcs;
  logic [3:0] chord_steps [NUM_VOICES];
  pc_t        root_reg;
  quality_t   quality_reg;
  quality_t   quality_next;
  logic [2:0] deg;

  logic        voices_in_span;
  logic        result_stall;
  logic [34:0] result_word;
  logic        ctrl_idle;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      key_pitch_class <= '0;
      mode_select <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY:  key_pitch_class <= cfg_data;
        REG_MODE: mode_select <= cfg_data[1:0];
        default:  ;
      endcase
    end
  end

  // handshake
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_advance;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire || (s1_valid && !s1_advance);
      out_valid <= s1_advance || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_degree <= degree;
      s1_fresh <= fresh_start;
    end
  end

  // chord tones: degrees d, d+2, d+4, d+6 modulo 7; degree 7 acts as 0
  assign deg = (s1_degree == 3'd7) ? 3'd0 : s1_degree;

  always_comb begin
    logic [3:0] idx;
    for (int k = 0; k < NUM_VOICES; k++) begin
      idx = {1'b0, deg} + 4'(2 * k);
      if (idx >= 4'd7) idx = idx - 4'd7;
      chord_steps[k] = MODE_STEPS[mode_select][idx[2:0]];
      tone_pcs[k] = pc_wrap({1'b0, key_pitch_class} + {1'b0, chord_steps[k]});
    end
  end

  function automatic logic [3:0] interval(logic [3:0] step, logic [3:0] root);
    return (step >= root) ? step - root : step + 4'd12 - root;
  endfunction

  always_comb begin
    logic [3:0] third;
    logic [3:0] fifth;
    logic [3:0] seventh;
    third = interval(chord_steps[1], chord_steps[0]);
    fifth = interval(chord_steps[2], chord_steps[0]);
    seventh = interval(chord_steps[3], chord_steps[0]);
    if (third == 4'd4) quality_next = (seventh == 4'd11) ? QUAL_MAJ7 : QUAL_DOM7;
    else if (fifth == 4'd6) quality_next = QUAL_M7B5;
    else quality_next = (seventh == 4'd11) ? QUAL_MINMAJ7 : QUAL_MIN7;
  end

  cvl_voice_lead u_lead (
    .place       (!voices_valid || s1_fresh),
    .tone_pcs    (tone_pcs),
    .prev_voicing(voice_notes),
    .next_voicing(voice_notes_next)
  );

  // stored voicing and result register update together
  always_ff @(posedge clk) begin
    if (rst) begin
      voices_valid <= 1'b0;
      voice_notes <= '0;
    end else if (s1_advance) begin
      voices_valid <= 1'b1;
      voice_notes <= voice_notes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      root_reg <= tone_pcs[0];
      quality_reg <= quality_next;
    end
  end

  assign voice_zero = voice_notes[0];
  assign voice_one = voice_notes[1];
  assign voice_two = voice_notes[2];
  assign voice_three = voice_notes[3];
  assign root_pc = root_reg;
  assign quality = quality_reg;

  assign voices_in_span = (voice_notes[0] >= NOTE_LOW) && (voice_notes[0] <= NOTE_HIGH) &&
                          (voice_notes[1] >= NOTE_LOW) && (voice_notes[1] <= NOTE_HIGH) &&
                          (voice_notes[2] >= NOTE_LOW) && (voice_notes[2] <= NOTE_HIGH) &&
                          (voice_notes[3] >= NOTE_LOW) && (voice_notes[3] <= NOTE_HIGH);
  assign result_stall = out_valid && !out_ready;
  assign result_word = {voice_notes, root_reg, quality_reg};
  assign ctrl_idle = !s1_valid && !out_valid && !voices_valid;

  `CVL_ASSERT(a_voice_range, voices_valid |-> voices_in_span, "stored voice outside 40..67")
  `CVL_ASSERT(a_advance_result, s1_advance |=> (out_valid && voices_valid), "item lost")
  `CVL_ASSERT(a_no_overwrite, (in_fire && s1_valid) |-> s1_advance, "input register overwritten")
  `CVL_ASSERT(a_stall_holds, result_stall |=> $stable(result_word), "result changed in stall")
  `CVL_ASSERT_ALWAYS(a_reset_clears, rst |=> ctrl_idle, "reset left control state set")

endmodule

[rtl/core/cvl_voice_lead.sv]
// Voice placement and greedy nearest-tone voice leading, purely combinational.
// Depends on cvl_pkg.
module cvl_voice_lead
  import cvl_pkg::*;
(
  input  logic      place,
  input  tone_pcs_t tone_pcs,
  input  voicing_t  prev_voicing,
  output voicing_t  next_voicing
);

  always_comb begin
    logic [NUM_VOICES-1:0] used;
    logic [1:0]            best_j;
    logic [2:0]            best_mag;
    offset_t               best_off;
    offset_t               off;
    logic [2:0]            mag;
    pc_t                   vpc;
    note_t                 n;

    used = '0;
    best_j = '0;
    best_mag = '0;
    best_off = '0;
    off = '0;
    mag = '0;
    vpc = '0;
    n = '0;
    next_voicing = prev_voicing;
    for (int v = 0; v < NUM_VOICES; v++) begin
      if (place) begin
        n = apply_offset(HOME_NOTE[v], near_offset(tone_pcs[v], HOME_PC[v]));
      end else begin
        // lowest free tone index wins ties
        best_j = 2'd0;
        best_mag = 3'd7;
        best_off = '0;
        vpc = note_pc(prev_voicing[v]);
        for (int j = 0; j < NUM_VOICES; j++) begin
          off = near_offset(tone_pcs[j], vpc);
          mag = offset_mag(off);
          if (!used[j] && mag < best_mag) begin
            best_mag = mag;
            best_j = 2'(j);
            best_off = off;
          end
        end
        used[best_j] = 1'b1;
        n = apply_offset(prev_voicing[v], best_off);
      end
      next_voicing[v] = fold(n);
    end
  end

endmodule
